FILE: rtl/cplt_pkg.sv
// Shared constants, codes and control bundles for the piecewise-linear lookup.
package cplt_pkg;

  localparam int XW              = 24;
  localparam int YW              = 24;
  localparam int CNT_W           = 7;
  localparam int IDX_W           = 6;
  localparam int FRAC_W          = 16;
  localparam int DIV_STEPS       = FRAC_W;
  localparam int DEF_TABLE_DEPTH = 64;

  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(2);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic wr;         // store the accepted entry
    logic start;      // latch the query, read entry zero
    logic take_lo;    // entry zero on read data, read last entry
    logic take_hi;    // last entry on read data, read entry one
    logic pick_lo;    // answer is the first y
    logic pick_hi;    // answer is the last y
    logic scan_step;  // advance to the next breakpoint
    logic scan_stop;  // segment found, capture operands
    logic div_init;   // first quotient bit and y difference
    logic div_step;   // one restoring division step
    logic mul;        // weight times y difference
    logic add;        // apply step to lower y
    logic load_out;   // clamp and load output register
  } cplt_cmd_t;

  typedef struct packed {
    logic at_lo;
    logic at_hi;
    logic scan_done;
    logic div_done;
    logic out_free;
  } cplt_status_t;

endpackage

FILE: rtl/cplt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cplt_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/cplt_ctrl.sv
// Sequencing state machine for table writes and lookup queries.
module cplt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   cmd,
  output logic                   in_stall,
  input  cplt_pkg::cplt_status_t status,
  output cplt_pkg::cplt_cmd_t    ctl
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_LO   = 10'b0000000010,
    ST_HI   = 10'b0000000100,
    ST_CHK  = 10'b0000001000,
    ST_SCAN = 10'b0000010000,
    ST_DIV0 = 10'b0000100000,
    ST_DIV  = 10'b0001000000,
    ST_MUL  = 10'b0010000000,
    ST_ADD  = 10'b0100000000,
    ST_DONE = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   take_item;

  assign in_stall  = (state != ST_IDLE);
  assign take_item = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        if (take_item) begin
          if (cmd == cplt_pkg::CMD_QUERY) begin
            ctl.start  = 1'b1;
            state_next = ST_LO;
          end else begin
            ctl.wr = 1'b1;
          end
        end
      end
      ST_LO: begin
        ctl.take_lo = 1'b1;
        state_next  = ST_HI;
      end
      ST_HI: begin
        ctl.take_hi = 1'b1;
        state_next  = ST_CHK;
      end
      ST_CHK: begin
        if (status.at_lo) begin
          ctl.pick_lo = 1'b1;
          state_next  = ST_DONE;
        end else if (status.at_hi) begin
          ctl.pick_hi = 1'b1;
          state_next  = ST_DONE;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_done) begin
          ctl.scan_stop = 1'b1;
          state_next    = ST_DIV0;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      ST_DIV0: begin
        ctl.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        ctl.div_step = 1'b1;
        if (status.div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl.mul    = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        ctl.add    = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold the answer until the output register can take it
        if (status.out_free) begin
          ctl.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.load_out |-> status.out_free)
    else $error("result loaded while output item still waiting");

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (take_item && cmd == cplt_pkg::CMD_QUERY) |=> in_stall)
    else $error("input taken while a query is in progress");

  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state lost its one-hot code");

endmodule

FILE: rtl/cplt_dp.sv
// Breakpoint table, scan registers, divider, multiplier and output register.
module cplt_dp #(
  parameter int TABLE_DEPTH = cplt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cplt_pkg::cplt_cmd_t          ctl,
  output cplt_pkg::cplt_status_t       status,
  input  logic [cplt_pkg::IDX_W-1:0]   entry_index,
  input  logic [cplt_pkg::XW-1:0]      entry_x,
  input  logic [cplt_pkg::YW-1:0]      entry_y,
  input  logic [cplt_pkg::XW-1:0]      query_interval,
  input  logic                         cfg_write,
  input  logic [cplt_pkg::CNT_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [cplt_pkg::YW-1:0]      velocity
);

  localparam int XW   = cplt_pkg::XW;
  localparam int YW   = cplt_pkg::YW;
  localparam int FW   = cplt_pkg::FRAC_W;
  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int NW   = (AW + 1 > cplt_pkg::CNT_W) ? AW + 1 : cplt_pkg::CNT_W;
  localparam int DCW  = $clog2(cplt_pkg::DIV_STEPS);
  localparam int PW   = FW + 1 + YW;

  logic [cplt_pkg::CNT_W-1:0] entries_in_use;
  logic [NW-1:0]              n_raw, n_used;
  logic [AW-1:0]              last;

  logic                       ram_we, ram_re;
  logic [AW-1:0]              ram_raddr;
  logic [XW+YW-1:0]           ram_rdata;
  logic [XW-1:0]              rd_x;
  logic [YW-1:0]              rd_y;

  logic [XW-1:0]              xq, lo_x, hi_x, prev_x, num, den, rem;
  logic [YW-1:0]              lo_y, hi_y, prev_y, y0, y1, dy, res;
  logic [AW-1:0]              didx;
  logic                       dir, q16;
  logic [FW-1:0]              quo;
  logic [DCW-1:0]             div_cnt;
  logic [XW:0]                rem2;
  logic [PW-1:0]              prod;
  logic [YW:0]                step;
  logic [YW-1:0]              clamp_lo, clamp_out;

  // effective count: at least two, at most the table depth
  always_comb begin
    n_raw = NW'(entries_in_use);
    if (n_raw < NW'(2)) begin
      n_used = NW'(2);
    end else if (n_raw > NW'(TABLE_DEPTH)) begin
      n_used = NW'(TABLE_DEPTH);
    end else begin
      n_used = n_raw;
    end
    last = AW'(n_used - NW'(1));
  end

  assign ram_we = ctl.wr && (int'(entry_index) < TABLE_DEPTH);
  assign ram_re = ctl.start || ctl.take_lo || ctl.take_hi || ctl.scan_step;

  always_comb begin
    ram_raddr = '0;
    if (ctl.take_lo) begin
      ram_raddr = last;
    end else if (ctl.take_hi) begin
      ram_raddr = AW'(1);
    end else if (ctl.scan_step) begin
      ram_raddr = didx + AW'(1);
    end
  end

  cplt_ram #(
    .WIDTH (XW + YW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(entry_index)),
    .wdata ({entry_x, entry_y}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[XW+YW-1:YW];
  assign rd_y = ram_rdata[YW-1:0];

  assign rem2 = {rem, 1'b0};
  assign step = prod[PW-1:FW];

  assign status.at_lo     = (xq <= lo_x);
  assign status.at_hi     = (xq >= hi_x);
  assign status.scan_done = (didx == last) || (xq <= rd_x);
  assign status.div_done  = (div_cnt == DCW'(cplt_pkg::DIV_STEPS - 1));
  assign status.out_free  = !out_valid || !out_stall;

  always_comb begin
    clamp_lo  = (res < lo_y) ? lo_y : res;
    clamp_out = (clamp_lo > hi_y) ? hi_y : clamp_lo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= cplt_pkg::CNT_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        entries_in_use <= cfg_data;
      end
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      xq <= query_interval;
    end
    if (ctl.take_lo) begin
      lo_x   <= rd_x;
      lo_y   <= rd_y;
      prev_x <= rd_x;
      prev_y <= rd_y;
      if (xq < rd_x) begin
        xq <= rd_x;
      end
    end
    if (ctl.take_hi) begin
      hi_x <= rd_x;
      hi_y <= rd_y;
      didx <= AW'(1);
      if (xq > rd_x) begin
        xq <= rd_x;
      end
    end
    if (ctl.scan_step) begin
      prev_x <= rd_x;
      prev_y <= rd_y;
      didx   <= didx + AW'(1);
    end
    if (ctl.scan_stop) begin
      num <= xq - prev_x;
      den <= rd_x - prev_x;
      y0  <= prev_y;
      y1  <= rd_y;
    end
    if (ctl.div_init) begin
      // the weight reaches one only when the query sits on the upper breakpoint
      if (num >= den) begin
        q16 <= 1'b1;
        rem <= num - den;
      end else begin
        q16 <= 1'b0;
        rem <= num;
      end
      quo     <= '0;
      div_cnt <= '0;
      dir     <= (y1 < y0);
      dy      <= (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    end
    if (ctl.div_step) begin
      if (rem2 >= {1'b0, den}) begin
        rem <= XW'(rem2 - {1'b0, den});
        quo <= {quo[FW-2:0], 1'b1};
      end else begin
        rem <= rem2[XW-1:0];
        quo <= {quo[FW-2:0], 1'b0};
      end
      div_cnt <= div_cnt + DCW'(1);
    end
    if (ctl.mul) begin
      prod <= PW'({q16, quo} * dy);
    end
    if (ctl.add) begin
      if (dir) begin
        res <= YW'({1'b0, y0} - step);
      end else begin
        res <= YW'({1'b0, y0} + step);
      end
    end
    if (ctl.pick_lo) begin
      res <= lo_y;
    end
    if (ctl.pick_hi) begin
      res <= hi_y;
    end
    if (ctl.load_out) begin
      velocity <= clamp_out;
    end
  end

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_step |-> (didx < last))
    else $error("scan ran past the last breakpoint in use");

  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    ctl.div_init |-> (num <= den))
    else $error("query offset exceeds segment width");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |-> (rem < den))
    else $error("division remainder out of range");

endmodule

FILE: rtl/clamped_piecewise_linear_lookup.sv
// Top level of the clamped piecewise-linear table lookup.
// A write item gives no result. A query gives its velocity after scanning k
// breakpoints (1 to n-1, one per cycle through the table's single read port),
// then a restoring divider. Queries at or beyond the table ends skip the scan
// and the divider. One item at a time.
// Reset (rst, synchronous) sets entries_in_use to 2; table contents stay unset.
module clamped_piecewise_linear_lookup #(
  parameter int TABLE_DEPTH = cplt_pkg::DEF_TABLE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       cmd,
  input  logic [cplt_pkg::IDX_W-1:0] entry_index,
  input  logic [cplt_pkg::XW-1:0]    entry_x,
  input  logic [cplt_pkg::YW-1:0]    entry_y,
  input  logic [cplt_pkg::XW-1:0]    query_interval,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [cplt_pkg::YW-1:0]    velocity,
  input  logic                       cfg_write,
  input  logic [cplt_pkg::CNT_W-1:0] cfg_data
);

  cplt_pkg::cplt_cmd_t    ctl;
  cplt_pkg::cplt_status_t status;

  cplt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  cplt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .status         (status),
    .entry_index    (entry_index),
    .entry_x        (entry_x),
    .entry_y        (entry_y),
    .query_interval (query_interval),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .velocity       (velocity)
  );

endmodule
